>>> rtl/iia_pkg.sv
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and codes of the indexed insert/erase array unit.
// ----------------------------------------------------------------------------
package iia_pkg;

   // fixed field widths of the request and response beats
   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;
   localparam int INDEX_W  = 4;

   // command codes, the two unused codes are no-ops
   localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // request beat
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] word_in;
   } req_payload_type;

   // response beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_count;
      logic                has_word;
      logic [WORD_W-1:0]   word_out;
      logic [INDEX_W-1:0]  word_index;
      logic                last;
   } rsp_payload_type;

   // what one cell takes in at the next edge
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_LEFT,
      CELL_RIGHT,
      CELL_WRAP
   } cell_op_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

>>> rtl/iia_req_if.sv
// ----------------------------------------------------------------------------
// iia_req_if
// Request channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface iia_req_if;
   logic                     valid;
   logic                     ready;
   iia_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/iia_rsp_if.sv
// ----------------------------------------------------------------------------
// iia_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface iia_rsp_if;
   logic                     valid;
   logic                     ready;
   iia_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/indexed_insert_erase_array_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_erase_array_unit
// Ordered array of DEPTH words kept in a row of cells. Push, insert and
// erase move every later entry by one place at once, since each cell
// loads from its neighbor in parallel, so update commands are taken one
// per cycle while the result side keeps up, and each is answered by one
// beat on the cycle after it is taken. A dump of a non-empty array holds
// the input until its last beat, one beat per stored entry, one per cycle
// while the result side takes them, as the occupied cells rotate down
// through cell zero. A dump of an empty array answers with one beat like
// an update. A new command is taken only when the response register is
// empty or its beat leaves in the same cycle, so a stalled result holds
// the input back. Full pushes and inserts report full, an out-of-range
// insert or erase reports a range error, and neither changes the array.
// ----------------------------------------------------------------------------
module indexed_insert_erase_array_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   iia_req_if.sink   req,
   iia_rsp_if.source rsp
);

   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] load_word;
   iia_pkg::cell_op_type  cell_op [DEPTH];

   // command decode and sequencing
   iia_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .head_word (cell_word[0]),
      .load_word (load_word),
      .cell_op   (cell_op)
   );

   // chain of cells, ends tied to themselves
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;

      if (i == 0) begin : g_lo
         assign left_word = cell_word[i];
      end else begin : g_lo
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign right_word = cell_word[i];
      end else begin : g_hi
         assign right_word = cell_word[i+1];
      end

      iia_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .load_word  (load_word),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (cell_word[0]),
         .word       (cell_word[i])
      );
   end

endmodule

>>> rtl/iia_cell.sv
// ----------------------------------------------------------------------------
// iia_cell
// One array slot: holds a word, or takes the new word, the lower or upper
// neighbor's word, or the head word, as its op says.
// ----------------------------------------------------------------------------
module iia_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  iia_pkg::cell_op_type  op,
   input  logic [DATA_WIDTH-1:0] load_word,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   input  logic [DATA_WIDTH-1:0] head_word,
   output logic [DATA_WIDTH-1:0] word
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // next value select
   always_comb begin
      case (op)
         iia_pkg::CELL_LOAD:  word_in = load_word;
         iia_pkg::CELL_LEFT:  word_in = left_word;
         iia_pkg::CELL_RIGHT: word_in = right_word;
         iia_pkg::CELL_WRAP:  word_in = head_word;
         default:             word_in = word_ff;
      endcase
   end

   // storage, no reset on data
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> rtl/iia_ctrl.sv
// ----------------------------------------------------------------------------
// iia_ctrl
// Command decode, fill count, dump sequencer and response register; steers
// every cell of the chain with a per-cell op.
// ----------------------------------------------------------------------------
module iia_ctrl #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   iia_req_if.sink               req,
   iia_rsp_if.source             rsp,
   input  logic [DATA_WIDTH-1:0] head_word,
   output logic [DATA_WIDTH-1:0] load_word,
   output iia_pkg::cell_op_type  cell_op [DEPTH]
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > iia_pkg::POS_W) ? CNT_W : iia_pkg::POS_W;

   iia_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [iia_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [iia_pkg::FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic                          rsp_has_ff, rsp_has_in;
   logic [iia_pkg::WORD_W-1:0]    rsp_word_ff, rsp_word_in;
   logic [iia_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic             slot_free;
   logic             req_ready;
   logic             accept;
   logic             rsp_load;
   logic             full;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [IDX_W-1:0] cnt_m1;
   logic             dump_last;
   logic [63:0]      in_wide;
   logic [63:0]      head_wide;

   // handshake
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req_ready = (state_ff == iia_pkg::ST_IDLE) && slot_free;
   assign req.ready = req_ready;
   assign accept    = req.valid && req_ready;

   // operand widening
   assign in_wide   = 64'(req.payload.word_in);
   assign load_word = in_wide[DATA_WIDTH-1:0];
   assign head_wide = 64'(head_word);
   assign pos_ext   = CMP_W'(req.payload.position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign cnt_m1    = IDX_W'(count_ff - CNT_W'(1));
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign dump_last = (idx_ff == cnt_m1);

   // next state, cell ops and response beat
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_status_in = iia_pkg::STATUS_OK;
      rsp_has_in    = 1'b0;
      rsp_word_in   = '0;
      rsp_index_in  = '0;
      rsp_last_in   = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         cell_op[i] = iia_pkg::CELL_HOLD;
      end

      case (state_ff)
         iia_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req.payload.command)
                  iia_pkg::CMD_APPEND: begin
                     if (full) begin
                        rsp_status_in = iia_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                           if (CMP_W'(i) == cnt_ext) cell_op[i] = iia_pkg::CELL_LOAD;
                        end
                     end
                  end
                  iia_pkg::CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = iia_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                           cell_op[i] = (i == 0) ? iia_pkg::CELL_LOAD : iia_pkg::CELL_LEFT;
                        end
                     end
                  end
                  iia_pkg::CMD_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        rsp_status_in = iia_pkg::STATUS_RANGE;
                     end else if (full) begin
                        rsp_status_in = iia_pkg::STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                           if (CMP_W'(i) == pos_ext) begin
                              cell_op[i] = iia_pkg::CELL_LOAD;
                           end else if (CMP_W'(i) > pos_ext) begin
                              cell_op[i] = iia_pkg::CELL_LEFT;
                           end
                        end
                     end
                  end
                  iia_pkg::CMD_ERASE: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = iia_pkg::STATUS_RANGE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        // top cell has no upper neighbor, it is past the count anyway
                        for (int i = 0; i < DEPTH - 1; i++) begin
                           if (CMP_W'(i) >= pos_ext) cell_op[i] = iia_pkg::CELL_RIGHT;
                        end
                     end
                  end
                  iia_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  iia_pkg::CMD_DUMP: begin
                     // empty array answers at once, otherwise walk the chain
                     if (count_ff != '0) begin
                        rsp_load = 1'b0;
                        state_in = iia_pkg::ST_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         iia_pkg::ST_DUMP: begin
            // rotate the occupied part of the chain down, head wraps to the top
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_has_in   = 1'b1;
               rsp_word_in  = head_wide[iia_pkg::WORD_W-1:0];
               rsp_index_in = iia_pkg::INDEX_W'(idx_ff);
               rsp_last_in  = dump_last;
               idx_in       = idx_ff + IDX_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (IDX_W'(i) == cnt_m1) begin
                     cell_op[i] = iia_pkg::CELL_WRAP;
                  end else if (IDX_W'(i) < cnt_m1) begin
                     cell_op[i] = iia_pkg::CELL_RIGHT;
                  end
               end
               if (dump_last) state_in = iia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iia_pkg::ST_IDLE;
         end
      endcase

      rsp_fill_in = iia_pkg::FILL_W'(count_in);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iia_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_has_ff    <= rsp_has_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.payload.status     = rsp_status_ff;
   assign rsp.payload.fill_count = rsp_fill_ff;
   assign rsp.payload.has_word   = rsp_has_ff;
   assign rsp.payload.word_out   = rsp_word_ff;
   assign rsp.payload.word_index = rsp_index_ff;
   assign rsp.payload.last       = rsp_last_ff;

endmodule

>>> tb/array_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_checker
// Watches the command and result channels of the array unit. Every command
// beat taken is run through a local copy of the array and fill count, the
// answer beats are queued, and each result beat is compared field by field
// against the oldest queued answer.
// ----------------------------------------------------------------------------
module array_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  iia_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  iia_pkg::rsp_payload_type rsp_payload,
   output int unsigned              mismatch_count,
   output int unsigned              beats_owed,
   output int unsigned              beats_checked
);

   localparam int REPORT_LIMIT = 100;
   localparam int WORD_W       = iia_pkg::WORD_W;
   localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // local copy of the array contents and fill count
   logic [WORD_W-1:0]          array_words [DEPTH];
   logic [iia_pkg::FILL_W-1:0] array_fill;

   // answers still owed by the unit, oldest first
   iia_pkg::rsp_payload_type   owed_answers [$];

   int unsigned                errors = 0;
   int unsigned                checked = 0;

   assign mismatch_count = errors;
   assign beats_checked  = checked;

   // add one answer at the young end of the owed queue
   function automatic void owe_answer(iia_pkg::rsp_payload_type answer);
      owed_answers.insert(owed_answers.size(), answer);
   endfunction

   // one-beat answer of an update command, fill taken after the update
   function automatic iia_pkg::rsp_payload_type update_answer(
         logic [iia_pkg::STATUS_W-1:0] status);
      iia_pkg::rsp_payload_type answer;
      answer            = '0;
      answer.status     = status;
      answer.fill_count = array_fill;
      answer.last       = 1'b1;
      return answer;
   endfunction

   // open a slot at the given place by moving later entries up
   function automatic void shift_in(int unsigned at, logic [WORD_W-1:0] word);
      int unsigned slot;
      for (slot = 32'(array_fill); slot > at; slot--) begin
         array_words[IDX_W'(slot)] = array_words[IDX_W'(slot - 1)];
      end
      array_words[IDX_W'(at)] = word;
      array_fill              = array_fill + 1'b1;
   endfunction

   // apply one command to the local array and queue the answers it causes
   function automatic void predict_command(iia_pkg::req_payload_type beat);
      logic [iia_pkg::STATUS_W-1:0] status;
      iia_pkg::rsp_payload_type     answer;
      int unsigned                  slot;
      status = iia_pkg::STATUS_OK;
      case (beat.command)
         iia_pkg::CMD_APPEND: begin
            if (array_fill == DEPTH) status = iia_pkg::STATUS_FULL;
            else shift_in(32'(array_fill), beat.word_in);
         end
         iia_pkg::CMD_PUSH_FRONT: begin
            if (array_fill == DEPTH) status = iia_pkg::STATUS_FULL;
            else shift_in(0, beat.word_in);
         end
         iia_pkg::CMD_INSERT: begin
            // range check wins over the full check
            if (beat.position > array_fill) status = iia_pkg::STATUS_RANGE;
            else if (array_fill == DEPTH) status = iia_pkg::STATUS_FULL;
            else shift_in(32'(beat.position), beat.word_in);
         end
         iia_pkg::CMD_ERASE: begin
            if (beat.position >= array_fill) begin
               status = iia_pkg::STATUS_RANGE;
            end else begin
               for (slot = 32'(beat.position); slot + 1 < 32'(array_fill); slot++) begin
                  array_words[IDX_W'(slot)] = array_words[IDX_W'(slot + 1)];
               end
               array_fill = array_fill - 1'b1;
            end
         end
         iia_pkg::CMD_CLEAR: begin
            array_fill = '0;
         end
         iia_pkg::CMD_DUMP: begin
            // empty dump answers with a single wordless beat
            if (array_fill == 0) begin
               owe_answer(update_answer(iia_pkg::STATUS_OK));
            end else begin
               for (slot = 0; slot < 32'(array_fill); slot++) begin
                  answer            = '0;
                  answer.status     = iia_pkg::STATUS_OK;
                  answer.fill_count = array_fill;
                  answer.has_word   = 1'b1;
                  answer.word_out   = array_words[IDX_W'(slot)];
                  answer.word_index = slot[iia_pkg::INDEX_W-1:0];
                  answer.last       = (slot + 1 == 32'(array_fill));
                  owe_answer(answer);
               end
            end
            return;
         end
         default: begin
            // unused codes leave the array alone
         end
      endcase
      owe_answer(update_answer(status));
   endfunction

   function automatic void flag_field(string field, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
      errors++;
      if (errors <= REPORT_LIMIT) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   // compare one result beat against the oldest owed answer
   function automatic void check_beat(iia_pkg::rsp_payload_type got);
      iia_pkg::rsp_payload_type want;
      if (owed_answers.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%0t: result beat with none owed, expected nothing, got %h", $time, got);
         end
         return;
      end
      want = owed_answers.pop_front();
      checked++;
      if (got.status !== want.status) begin
         flag_field("status", WORD_W'(want.status), WORD_W'(got.status));
      end
      if (got.fill_count !== want.fill_count) begin
         flag_field("fill_count", WORD_W'(want.fill_count), WORD_W'(got.fill_count));
      end
      if (got.has_word !== want.has_word) begin
         flag_field("has_word", WORD_W'(want.has_word), WORD_W'(got.has_word));
      end
      if (got.word_out !== want.word_out) flag_field("word_out", want.word_out, got.word_out);
      if (got.word_index !== want.word_index) begin
         flag_field("word_index", WORD_W'(want.word_index), WORD_W'(got.word_index));
      end
      if (got.last !== want.last) begin
         flag_field("last", WORD_W'(want.last), WORD_W'(got.last));
      end
   endfunction

   // results first: a beat never answers a command taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         array_fill = '0;
         owed_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_beat(rsp_payload);
         if (req_valid && req_ready) predict_command(req_payload);
      end
      beats_owed <= owed_answers.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the indexed insert/erase array unit: a directed
// walk through empty, full and out-of-range cases, then random editing,
// fill-to-full, drain-and-clear and noise sequences, with random stalls on both channels.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH        = 16;
   localparam int TARGET_ITEMS = 360;
   localparam int STALL_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 20;
   localparam int CMD_W        = iia_pkg::CMD_W;
   localparam int POS_W        = iia_pkg::POS_W;
   localparam int WORD_W       = iia_pkg::WORD_W;

   // the two command codes the unit treats as no-ops
   localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

   logic        clock;
   logic        reset;
   logic        idle_enable;
   int unsigned items_sent;
   int unsigned sent_per_command [8];
   int          shape_fill;
   int unsigned mismatch_count;
   int unsigned beats_owed;
   int unsigned beats_checked;

   iia_req_if req_ch ();
   iia_rsp_if rsp_ch ();

   indexed_insert_erase_array_unit #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (WORD_W)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   array_list_checker #(
      .DEPTH (DEPTH)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_payload    (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_payload    (rsp_ch.payload),
      .mismatch_count (mismatch_count),
      .beats_owed     (beats_owed),
      .beats_checked  (beats_checked)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idle_enable || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // data words with the all-zero and all-one patterns mixed in
   function automatic logic [WORD_W-1:0] random_word();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      return $urandom;
   endfunction

   // present one command beat and hold it until taken
   task automatic send_command(input logic [CMD_W-1:0] command,
                               input logic [POS_W-1:0] position,
                               input logic [WORD_W-1:0] word);
      iia_pkg::req_payload_type beat;
      int unsigned              gap;
      beat.command  = command;
      beat.position = position;
      beat.word_in  = word;
      req_ch.payload <= beat;
      req_ch.valid   <= 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
      sent_per_command[command]++;
      // rough fill tracking, only used to aim positions
      case (command)
         iia_pkg::CMD_APPEND, iia_pkg::CMD_PUSH_FRONT: if (shape_fill < DEPTH) shape_fill++;
         iia_pkg::CMD_INSERT: if (position <= shape_fill && shape_fill < DEPTH) shape_fill++;
         iia_pkg::CMD_ERASE: if (position < shape_fill) shape_fill--;
         iia_pkg::CMD_CLEAR: shape_fill = 0;
         default: ;
      endcase
      gap = idle_cycles();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new commands until every owed result has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beats_owed != 0) @(posedge clock);
   endtask

   // one update command with a position that is usually in range
   task automatic send_update();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         send_command(iia_pkg::CMD_APPEND, POS_W'($urandom), random_word());
      end else if (roll < 45) begin
         send_command(iia_pkg::CMD_PUSH_FRONT, POS_W'($urandom), random_word());
      end else if (roll < 70) begin
         send_command(iia_pkg::CMD_INSERT, POS_W'($urandom_range(0, shape_fill)),
                      random_word());
      end else if (shape_fill > 0 && roll < 95) begin
         send_command(iia_pkg::CMD_ERASE, POS_W'($urandom_range(0, shape_fill - 1)),
                      random_word());
      end else begin
         send_command(iia_pkg::CMD_ERASE, POS_W'($urandom_range(shape_fill, 31)),
                      random_word());
      end
   endtask

   // result side stalls
   initial begin : result_stalls
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = idle_cycles();
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // no beat moving for too long ends the run
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("testbench failed");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      int unsigned k;
      int unsigned kind;
      items_sent     = 0;
      shape_fill     = 0;
      idle_enable    = 1'b1;
      foreach (sent_per_command[i]) sent_per_command[i] = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, fill to capacity, full and range errors
      send_command(iia_pkg::CMD_DUMP, '0, '0);
      send_command(iia_pkg::CMD_ERASE, 5'd0, '0);
      send_command(iia_pkg::CMD_INSERT, 5'd0, '1);
      send_command(iia_pkg::CMD_PUSH_FRONT, 5'd31, '0);
      for (k = 0; k < 14; k++) begin
         case (k % 3)
            0: send_command(iia_pkg::CMD_APPEND, '0, $urandom);
            1: send_command(iia_pkg::CMD_PUSH_FRONT, '0, $urandom);
            default: send_command(iia_pkg::CMD_INSERT, POS_W'($urandom_range(0, shape_fill)),
                                  $urandom);
         endcase
      end
      send_command(iia_pkg::CMD_APPEND, '0, $urandom);
      send_command(iia_pkg::CMD_PUSH_FRONT, '0, $urandom);
      send_command(iia_pkg::CMD_INSERT, 5'd16, $urandom);
      send_command(iia_pkg::CMD_INSERT, 5'd31, $urandom);
      send_command(iia_pkg::CMD_DUMP, '0, '0);
      send_command(iia_pkg::CMD_ERASE, 5'd16, '0);
      send_command(iia_pkg::CMD_ERASE, 5'd15, '0);
      send_command(iia_pkg::CMD_ERASE, 5'd0, '0);
      send_command(CMD_UNUSED_A, POS_W'($urandom), $urandom);
      send_command(CMD_UNUSED_B, POS_W'($urandom), $urandom);
      send_command(iia_pkg::CMD_CLEAR, '0, '0);
      send_command(iia_pkg::CMD_DUMP, '0, '0);
      wait_for_results();

      // random sequences, some phases without any idling
      while (items_sent < TARGET_ITEMS) begin
         idle_enable = ($urandom_range(0, 4) != 0);
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            // editing burst closed by a dump
            repeat ($urandom_range(4, 16)) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_command(iia_pkg::CMD_DUMP, POS_W'($urandom), $urandom);
               end else begin
                  send_update();
               end
            end
            send_command(iia_pkg::CMD_DUMP, POS_W'($urandom), $urandom);
         end else if (kind < 7) begin
            // fill up, poke the full array, then trim back
            while (shape_fill < DEPTH) send_update();
            send_command(iia_pkg::CMD_APPEND, POS_W'($urandom), random_word());
            send_command(iia_pkg::CMD_PUSH_FRONT, POS_W'($urandom), random_word());
            send_command(iia_pkg::CMD_INSERT, POS_W'($urandom_range(0, DEPTH)),
                         random_word());
            send_command(iia_pkg::CMD_INSERT, POS_W'($urandom_range(DEPTH + 1, 31)),
                         random_word());
            send_command(iia_pkg::CMD_DUMP, POS_W'($urandom), $urandom);
            repeat ($urandom_range(1, 8)) begin
               send_command(iia_pkg::CMD_ERASE, POS_W'($urandom_range(0, shape_fill - 1)),
                            $urandom);
            end
            send_command(iia_pkg::CMD_DUMP, POS_W'($urandom), $urandom);
         end else if (kind == 7) begin
            // let the unit drain, then empty it
            wait_for_results();
            send_command(iia_pkg::CMD_CLEAR, POS_W'($urandom), $urandom);
            send_command(iia_pkg::CMD_DUMP, POS_W'($urandom), $urandom);
         end else begin
            // noise: any code, any position
            repeat ($urandom_range(4, 10)) begin
               send_command(CMD_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 31)),
                            random_word());
            end
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d commands: %0d append, %0d push front, %0d insert, %0d erase,",
               items_sent, sent_per_command[iia_pkg::CMD_APPEND],
               sent_per_command[iia_pkg::CMD_PUSH_FRONT],
               sent_per_command[iia_pkg::CMD_INSERT], sent_per_command[iia_pkg::CMD_ERASE]);
      $display("%0d clear, %0d dump, %0d unused codes; %0d result beats compared",
               sent_per_command[iia_pkg::CMD_CLEAR], sent_per_command[iia_pkg::CMD_DUMP],
               sent_per_command[CMD_UNUSED_A] + sent_per_command[CMD_UNUSED_B], beats_checked);
      if (mismatch_count == 0 && beats_owed == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> indexed_insert_erase_array_unit.f
rtl/iia_pkg.sv
rtl/iia_req_if.sv
rtl/iia_rsp_if.sv
rtl/iia_cell.sv
rtl/iia_ctrl.sv
rtl/indexed_insert_erase_array_unit.sv
tb/array_list_checker.sv
tb/testbench.sv
